>>> hdl/cld_pkg.sv
// shared types, constants and lookup functions for the content-length deframer
`timescale 1ns / 1ps
package cld_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int ACC_W       = LENGTH_BITS + 1;
   localparam int PROD_W      = ACC_W + 4;
   localparam logic [ACC_W-1:0] ACC_LIMIT = ACC_W'(1) << LENGTH_BITS;

   localparam int KW_LEN  = 15;
   localparam int KW_W    = 4;
   localparam int SEP_W   = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_C = 8'h43;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic {
      PHASE_HEADER = 1'b0,
      PHASE_BODY   = 1'b1
   } phase_type;

   typedef enum logic [2:0] {
      VS_SEEK   = 3'd0,
      VS_BLANKS = 3'd1,
      VS_MINUS  = 3'd2,
      VS_POS    = 3'd3,
      VS_NEG    = 3'd4,
      VS_OK     = 3'd5,
      VS_BAD    = 3'd6
   } value_state_type;

   // one classified request byte as it sits in the queue
   typedef struct packed {
      logic [7:0] data;
      logic       is_digit;
      logic       is_blank;
      logic       is_minus;
      logic       is_cr;
      logic       is_upper_c;
   } entry_type;

   // "Content-Length:" by position
   function automatic logic [7:0] kw_char(input logic [KW_W-1:0] idx);
      logic [7:0] ch;
      begin
         unique case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3A; // :
            default: ch = 8'h00;
         endcase
         return ch;
      end
   endfunction

   // CR LF CR LF by position
   function automatic logic [7:0] sep_char(input logic [SEP_W-1:0] idx);
      return idx[0] ? CHAR_LF : CHAR_CR;
   endfunction

endpackage

>>> hdl/cld_front.sv
// front end: request handshake and byte classification into the queue
`timescale 1ns / 1ps
module cld_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_stream_byte,
   input  logic                 queue_full,
   output logic                 push,
   output cld_pkg::entry_type   push_entry
);
   import cld_pkg::*;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_entry.data       = req_stream_byte;
      push_entry.is_digit   = (req_stream_byte >= CHAR_ZERO) && (req_stream_byte <= CHAR_NINE);
      push_entry.is_blank   = (req_stream_byte == CHAR_SPACE) || (req_stream_byte == CHAR_TAB);
      push_entry.is_minus   = (req_stream_byte == CHAR_MINUS);
      push_entry.is_cr      = (req_stream_byte == CHAR_CR);
      push_entry.is_upper_c = (req_stream_byte == CHAR_UPPER_C);
   end

endmodule

>>> hdl/cld_queue.sv
// short queue of classified bytes between front and back
`timescale 1ns / 1ps
module cld_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cld_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output cld_pkg::entry_type   head_entry
);
   import cld_pkg::*;

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/cld_back.sv
// back end: header parsing, body pass-through and the response register
`timescale 1ns / 1ps
module cld_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  cld_pkg::entry_type              head_entry,
   output logic                            pop,
   input  logic                            csr_write_enable,
   input  logic [cld_pkg::LENGTH_BITS-1:0] csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_result_kind,
   output logic [7:0]                      rsp_body_byte,
   output logic                            rsp_last_of_body,
   output logic [cld_pkg::LENGTH_BITS-1:0] rsp_announced_length
);
   import cld_pkg::*;

   // parser state
   phase_type               phase_ff, phase_in;
   logic [SEP_W-1:0]        sep_ff, sep_in;
   logic [KW_W-1:0]         kw_ff, kw_in;
   value_state_type         vs_ff, vs_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [LENGTH_BITS-1:0]  rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]  max_ff, max_in;

   // response register
   logic                    out_valid_ff, out_valid_in;
   kind_type                out_kind_ff, out_kind_in;
   logic [7:0]              out_byte_ff, out_byte_in;
   logic                    out_last_ff, out_last_in;
   logic [LENGTH_BITS-1:0]  out_len_ff, out_len_in;

   // per-byte update terms
   logic [PROD_W-1:0]       prod;
   logic [ACC_W-1:0]        acc_dig;
   value_state_type         vs_upd;
   logic [KW_W-1:0]         kw_upd;
   logic [ACC_W-1:0]        acc_upd;
   logic [SEP_W-1:0]        sep_upd;
   logic                    sep_done;
   logic                    hdr_err;
   logic                    hdr_empty;
   logic                    body_last;

   // result of the byte at the queue head
   logic                    res_valid;
   kind_type                res_kind;
   logic [7:0]              res_byte;
   logic                    res_last;
   logic [LENGTH_BITS-1:0]  res_len;

   assign pop = head_valid && (!out_valid_ff || rsp_ready);

   // value field, keyword and separator tracking
   always_comb begin
      prod = (PROD_W'(acc_ff) << 3) + (PROD_W'(acc_ff) << 1)
           + PROD_W'(head_entry.data[3:0]);
      acc_dig = (prod > PROD_W'(ACC_LIMIT)) ? ACC_LIMIT : prod[ACC_W-1:0];

      vs_upd  = vs_ff;
      kw_upd  = kw_ff;
      acc_upd = acc_ff;
      unique case (vs_ff)
         VS_SEEK: begin
            if (head_entry.data == kw_char(kw_ff)) begin
               kw_upd = kw_ff + KW_W'(1);
            end else begin
               kw_upd = head_entry.is_upper_c ? KW_W'(1) : '0;
            end
            if (kw_upd == KW_W'(KW_LEN)) begin
               vs_upd = VS_BLANKS;
            end
         end
         VS_BLANKS: begin
            priority if (head_entry.is_blank) begin
               vs_upd = VS_BLANKS;
            end else if (head_entry.is_digit) begin
               vs_upd  = VS_POS;
               acc_upd = acc_dig;
            end else if (head_entry.is_minus) begin
               vs_upd = VS_MINUS;
            end else begin
               vs_upd = VS_BAD;
            end
         end
         VS_MINUS: begin
            if (head_entry.is_digit) begin
               vs_upd  = VS_NEG;
               acc_upd = acc_dig;
            end else begin
               vs_upd = VS_BAD;
            end
         end
         VS_POS: begin
            if (head_entry.is_digit) begin
               acc_upd = acc_dig;
            end else begin
               vs_upd = VS_OK;
            end
         end
         VS_NEG: begin
            if (head_entry.is_digit) begin
               acc_upd = acc_dig;
            end else begin
               vs_upd = (acc_ff == '0) ? VS_OK : VS_BAD;
            end
         end
         VS_OK:   vs_upd = VS_OK;
         default: vs_upd = VS_BAD;
      endcase

      if (head_entry.data == sep_char(sep_ff)) begin
         sep_upd = sep_ff + SEP_W'(1);
      end else begin
         sep_upd = head_entry.is_cr ? SEP_W'(1) : '0;
      end
      sep_done  = (sep_ff == SEP_W'(3)) && (head_entry.data == CHAR_LF);
      hdr_err   = (vs_upd != VS_OK) || (acc_upd > {1'b0, max_ff});
      hdr_empty = (acc_upd == '0);
      body_last = (rem_ff[LENGTH_BITS-1:1] == '0);
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      sep_in   = sep_ff;
      kw_in    = kw_ff;
      vs_in    = vs_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      max_in   = csr_write_enable ? csr_write_data : max_ff;
      if (pop) begin
         unique case (phase_ff)
            PHASE_BODY: begin
               if (body_last) begin
                  phase_in = PHASE_HEADER;
                  acc_in   = '0;
                  rem_in   = '0;
               end else begin
                  rem_in = rem_ff - LENGTH_BITS'(1);
               end
            end
            PHASE_HEADER: begin
               vs_in  = vs_upd;
               kw_in  = kw_upd;
               acc_in = acc_upd;
               sep_in = sep_upd;
               if (sep_done) begin
                  sep_in = '0;
                  kw_in  = '0;
                  vs_in  = VS_SEEK;
                  if (hdr_err || hdr_empty) begin
                     acc_in = '0;
                     rem_in = '0;
                  end else begin
                     phase_in = PHASE_BODY;
                     rem_in   = acc_upd[LENGTH_BITS-1:0];
                  end
               end
            end
            default: phase_in = PHASE_HEADER;
         endcase
      end
   end

   // result of the current byte
   always_comb begin
      res_valid = 1'b0;
      res_kind  = KIND_BODY;
      res_byte  = '0;
      res_last  = 1'b0;
      res_len   = '0;
      unique case (phase_ff)
         PHASE_BODY: begin
            res_valid = 1'b1;
            res_byte  = head_entry.data;
            res_last  = body_last;
            res_len   = acc_ff[LENGTH_BITS-1:0];
         end
         PHASE_HEADER: begin
            if (sep_done) begin
               priority if (hdr_err) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_ERROR;
               end else if (hdr_empty) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_EMPTY;
                  res_last  = 1'b1;
               end else begin
                  res_valid = 1'b0;
               end
            end
         end
         default: res_valid = 1'b0;
      endcase
   end

   // response register loads when the head byte leaves the queue and yields a result
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_len_in   = out_len_ff;
      if (pop && res_valid) begin
         out_valid_in = 1'b1;
         out_kind_in  = res_kind;
         out_byte_in  = res_byte;
         out_last_in  = res_last;
         out_len_in   = res_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HEADER;
         sep_ff       <= '0;
         kw_ff        <= '0;
         vs_ff        <= VS_SEEK;
         acc_ff       <= '0;
         rem_ff       <= '0;
         max_ff       <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sep_ff       <= sep_in;
         kw_ff        <= kw_in;
         vs_ff        <= vs_in;
         acc_ff       <= acc_in;
         rem_ff       <= rem_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_len_ff  <= out_len_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_result_kind      = out_kind_ff;
   assign rsp_body_byte        = out_byte_ff;
   assign rsp_last_of_body     = out_last_ff;
   assign rsp_announced_length = out_len_ff;

   a_body_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_BODY) |-> (rem_ff != '0))
      else $error("body phase with no bytes remaining");

   a_last_body_ends : assert property (@(posedge clock) disable iff (reset)
      (pop && (phase_ff == PHASE_BODY) && body_last) |=> (phase_ff == PHASE_HEADER))
      else $error("body phase did not end after its last byte");

   a_error_fields : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == KIND_ERROR)) |->
         (!out_last_ff && (out_len_ff == '0) && (out_byte_ff == '0)))
      else $error("header error response carries data");

   a_empty_fields : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_kind_ff == KIND_EMPTY)) |-> (out_last_ff && (out_len_ff == '0)))
      else $error("empty message response malformed");

endmodule

>>> hdl/content_length_message_deframer.sv
// top level of the content-length message deframer
`timescale 1ns / 1ps
// a request byte is registered in the queue and then in the response register before any response it yields shows
// throughput: one request byte per clock while the queue has room, set by the parser update in the back end
// a four-entry queue between front and back takes up to four requests during a response stall,
// after that req_ready drops until the response side moves again
// reset: synchronous, active high; clears the parser to header search, empties the queue,
// drops any pending response and sets the maximum body length to all ones
module content_length_message_deframer (
   input  logic                            clock,
   input  logic                            reset,
   // request channel: one raw stream byte per request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_stream_byte,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_result_kind,
   output logic [7:0]                      rsp_body_byte,
   output logic                            rsp_last_of_body,
   output logic [cld_pkg::LENGTH_BITS-1:0] rsp_announced_length,
   // maximum body length register
   input  logic                            csr_write_enable,
   input  logic [cld_pkg::LENGTH_BITS-1:0] csr_write_data
);
   import cld_pkg::*;

   // front to queue
   logic       push;
   entry_type  push_entry;
   logic       queue_full;

   // queue to back
   logic       pop;
   logic       head_valid;
   entry_type  head_entry;

   // front: takes a request whenever the queue has room and tags the byte
   // with the character classes the parser needs
   cld_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   // decoupling queue, so a stalled response side does not stop requests at once
   cld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back: keyword search, length parse, separator detect, body pass-through
   // and the response register
   cld_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_entry           (head_entry),
      .pop                  (pop),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_body_byte        (rsp_body_byte),
      .rsp_last_of_body     (rsp_last_of_body),
      .rsp_announced_length (rsp_announced_length)
   );

endmodule

>>> tb/deframe_checker.sv
// response predictor and scoreboard for the content-length message deframer
`timescale 1ns / 1ps
module deframe_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_stream_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [1:0]                      rsp_result_kind,
   input  logic [7:0]                      rsp_body_byte,
   input  logic                            rsp_last_of_body,
   input  logic [cld_pkg::LENGTH_BITS-1:0] rsp_announced_length,
   input  logic                            csr_write_enable,
   input  logic [cld_pkg::LENGTH_BITS-1:0] csr_write_data,
   output int                              mismatch_count,
   output int                              pending_count,
   output int                              body_seen,
   output int                              empty_seen,
   output int                              error_seen
);
   import cld_pkg::*;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             data;
      logic                   last;
      logic [LENGTH_BITS-1:0] length;
   } deframed_type;

   deframed_type           expected_responses[$];
   deframed_type           got;
   deframed_type           want;

   // predictor copy of the parser and the length register
   phase_type              parse_phase;
   int unsigned            sep_match;
   int unsigned            key_match;
   value_state_type        value_state;
   longint unsigned        length_acc;
   longint unsigned        body_left;
   logic [LENGTH_BITS-1:0] length_limit;

   int    mismatches = 0;
   int    n_body     = 0;
   int    n_empty    = 0;
   int    n_error    = 0;
   string keyword_text = "Content-Length:";

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic void restart_header();
      parse_phase = PHASE_HEADER;
      sep_match   = 0;
      key_match   = 0;
      value_state = VS_SEEK;
      length_acc  = 0;
      body_left   = 0;
   endfunction

   // decimal accumulate, saturating one above the widest length
   function automatic void add_digit(input logic [7:0] b);
      longint unsigned ceiling;
      longint unsigned next;
      ceiling    = longint'(1) << LENGTH_BITS;
      next       = length_acc * 10 + (b - CHAR_ZERO);
      length_acc = (next > ceiling) ? ceiling : next;
   endfunction

   function automatic void track_value(input logic [7:0] b);
      logic digit;
      digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      case (value_state)
         VS_SEEK: begin
            if (key_match < KW_LEN) begin
               if (b == keyword_text[key_match]) key_match++;
               else key_match = (b == CHAR_UPPER_C) ? 1 : 0;
               if (key_match == KW_LEN) value_state = VS_BLANKS;
            end
         end
         VS_BLANKS: begin
            if (b == CHAR_SPACE || b == CHAR_TAB) ;
            else if (digit) begin
               value_state = VS_POS;
               add_digit(b);
            end
            else if (b == CHAR_MINUS) value_state = VS_MINUS;
            else value_state = VS_BAD;
         end
         VS_MINUS: begin
            if (digit) begin
               value_state = VS_NEG;
               add_digit(b);
            end
            else value_state = VS_BAD;
         end
         VS_POS: begin
            if (digit) add_digit(b);
            else value_state = VS_OK;
         end
         VS_NEG: begin
            if (digit) add_digit(b);
            else value_state = (length_acc == 0) ? VS_OK : VS_BAD;
         end
         VS_OK: ;
         default: value_state = VS_BAD;
      endcase
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      deframed_type r;
      if (parse_phase == PHASE_BODY) begin
         r.kind   = KIND_BODY;
         r.data   = b;
         r.last   = (body_left <= 1);
         r.length = length_acc[LENGTH_BITS-1:0];
         expected_responses.push_back(r);
         if (body_left <= 1) restart_header();
         else body_left--;
         return;
      end
      track_value(b);
      if (b == (sep_match[0] ? CHAR_LF : CHAR_CR)) sep_match++;
      else sep_match = (b == CHAR_CR) ? 1 : 0;
      if (sep_match < 4) return;
      r.data   = '0;
      r.length = '0;
      if (value_state != VS_OK || length_acc > length_limit) begin
         restart_header();
         r.kind = KIND_ERROR;
         r.last = 1'b0;
         expected_responses.push_back(r);
      end
      else if (length_acc == 0) begin
         restart_header();
         r.kind = KIND_EMPTY;
         r.last = 1'b1;
         expected_responses.push_back(r);
      end
      else begin
         parse_phase = PHASE_BODY;
         sep_match   = 0;
         key_match   = 0;
         value_state = VS_SEEK;
         body_left   = length_acc;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_header();
         length_limit = '1;
         expected_responses.delete();
      end
      else begin
         // a response can never stem from a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got.kind   = kind_type'(rsp_result_kind);
            got.data   = rsp_body_byte;
            got.last   = rsp_last_of_body;
            got.length = rsp_announced_length;
            case (got.kind)
               KIND_BODY:  n_body++;
               KIND_EMPTY: n_empty++;
               default:    n_error++;
            endcase
            if (expected_responses.size() == 0)
               report_mismatch($sformatf("unexpected response kind %0d byte %02h",
                                         got.kind, got.data));
            else begin
               want = expected_responses.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "kind %0d byte %02h last %b length %0d, wanted %0d %02h %b %0d",
                     got.kind, got.data, got.last, got.length,
                     want.kind, want.data, want.last, want.length));
            end
         end
         if (csr_write_enable) length_limit = csr_write_data;
         if (req_valid && req_ready) deframe_byte(req_stream_byte);
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_responses.size();
      body_seen      <= n_body;
      empty_seen     <= n_empty;
      error_seen     <= n_error;
   end

endmodule

>>> tb/testbench.sv
// stimulus and verdict for the content-length message deframer
`timescale 1ns / 1ps
module testbench;
   import cld_pkg::*;

   localparam int RANDOM_BYTES = 1150;
   localparam int CALM_BYTES   = 200;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_stream_byte  = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [1:0]             rsp_result_kind;
   logic [7:0]             rsp_body_byte;
   logic                   rsp_last_of_body;
   logic [LENGTH_BITS-1:0] rsp_announced_length;
   logic                   csr_write_enable = 1'b0;
   logic [LENGTH_BITS-1:0] csr_write_data   = '0;

   int mismatch_total;
   int responses_pending;
   int body_count;
   int empty_count;
   int error_count;

   // pacing: percent chance per request of a sender gap, per cycle of a receiver stall
   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_left = 0;

   logic [7:0]             frame_bytes[$];
   logic [LENGTH_BITS-1:0] length_limit  = '1;
   int                     bytes_sent    = 0;
   int                     limit_writes  = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   content_length_message_deframer u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_stream_byte      (req_stream_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_body_byte        (rsp_body_byte),
      .rsp_last_of_body     (rsp_last_of_body),
      .rsp_announced_length (rsp_announced_length),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   deframe_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_stream_byte      (req_stream_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_body_byte        (rsp_body_byte),
      .rsp_last_of_body     (rsp_last_of_body),
      .rsp_announced_length (rsp_announced_length),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .mismatch_count       (mismatch_total),
      .pending_count        (responses_pending),
      .body_seen            (body_count),
      .empty_seen           (empty_count),
      .error_seen           (error_count)
   );

   // receiver: ready drops in bursts of random length while stalls are enabled
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end
      else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end
      else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end
      else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request; valid stays up into the next request unless a gap is taken
   task automatic send_byte(input logic [7:0] b);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endtask

   task automatic flush_bytes();
      while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front());
   endtask

   // header text followed by random body content, then off it goes
   task automatic frame(input string hdr, input int body_len);
      put_text(hdr);
      repeat (body_len) frame_bytes.push_back(8'($urandom_range(0, 255)));
      flush_bytes();
   endtask

   // hold off until every predicted response is back and the queue has emptied
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (responses_pending != 0);
      // header bytes in flight give no response, so allow for the queue depth
      repeat (12) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LENGTH_BITS-1:0] v);
      drain_results();
      csr_write_data   <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_limit = v;
      limit_writes++;
   endtask

   function automatic string random_word(input int n);
      string s;
      s = "";
      repeat (n) s = $sformatf("%s%c", s, 8'($urandom_range(8'h61, 8'h7A)));
      return s;
   endfunction

   task automatic put_field_lines(input int n);
      repeat (n)
         put_text($sformatf("%s: %s\r\n", random_word($urandom_range(1, 8)),
                            random_word($urandom_range(1, 12))));
   endtask

   function automatic int pick_pace();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 35;
      endcase
   endfunction

   // well-formed header with random surroundings and a length the block will accept
   task automatic good_message();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
      if (longint'(len) > longint'(length_limit)) len = int'(length_limit);
      put_field_lines($urandom_range(0, 2));
      put_text("Content-Length:");
      repeat ($urandom_range(0, 3)) put_text($urandom_range(0, 1) ? " " : "\t");
      if (len == 0 && $urandom_range(0, 3) == 0) put_text("-0");
      else begin
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) put_text("0");
         put_text($sformatf("%0d", len));
      end
      if ($urandom_range(0, 4) == 0) put_text(random_word($urandom_range(1, 4)));
      put_text("\r\n");
      put_field_lines($urandom_range(0, 2));
      // a second length line must be ignored
      if ($urandom_range(0, 5) == 0) put_text("Content-Length: 99\r\n");
      frame("\r\n", len);
   endtask

   task automatic broken_message();
      longint unsigned huge;
      case ($urandom_range(0, 6))
         0: begin
            put_field_lines($urandom_range(1, 3));
            frame("\r\n", 0);
         end
         1: frame($urandom_range(0, 1) ? "Content-Length: \r\n\r\n"
                                       : "Content-Length: x5\r\n\r\n", 0);
         2: frame($urandom_range(0, 1) ? "Content-Length: -\r\n\r\n"
                                       : "Content-Length:-x\r\n\r\n", 0);
         3: frame($sformatf("Content-Length: -%0d\r\n\r\n", $urandom_range(1, 99999)), 0);
         4: begin
            huge = longint'(length_limit) + 1 + $urandom_range(0, 1000);
            frame($sformatf("Content-Length: %0d\r\n\r\n", huge), 0);
         end
         5: frame($urandom_range(0, 1) ? "Content-length: 5\r\n\r\n"
                                       : "Content-Length 5\r\n\r\n", 0);
         default: frame("Content-\r\n\r\n", 0);
      endcase
   endtask

   // raw bytes with no keyword, closed off by a separator so the parser resynchronises
   task automatic noise_message();
      repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame("\r\n\r\n", 0);
   endtask

   initial begin
      int pick;
      int wait_cycles;
      int random_target;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: plain lengths, blanks and leading zeros, then malformed forms
      gap_pct   = 20;
      stall_pct = 20;
      frame("Content-Length: 5\r\n\r\n", 5);
      frame("Content-Length: 0\r\n\r\n", 0);
      frame("Content-Length:1\r\n\r\n", 1);
      frame("Content-Length: \t 007\r\n\r\n", 7);
      frame("Content-Type: text\r\n\r\n", 0);
      frame("Content-Length: \r\n\r\n", 0);
      frame("Content-Length: x12\r\n\r\n", 0);
      frame("Content-Length: -\r\n\r\n", 0);
      frame("Content-Length: -3\r\n\r\n", 0);
      frame("Content-Length: -0\r\n\r\n", 0);
      frame("Content-Length: 16777216\r\n\r\n", 0);
      frame("Content-Length: 99999999999\r\n\r\n", 0);
      frame("Content-Length: 2\r\nContent-Length: 9\r\n\r\n", 2);
      frame("CContent-LengtContent-Length: 3\r\n\r\n", 3);
      frame("Content-Length: 4abc\r\n\r\n", 4);
      frame("Content-Length: 2\r\n\r\r\n\r\n", 2);
      frame("\r\n\r\n", 0);
      frame("content-length: 5\r\n\r\n", 0);
      // body that looks like a whole header is still just data
      frame("Content-Length: 25\r\n\r\n\r\n\r\nContent-Length: 1\r\n\r\n", 0);
      // all-zero and all-one body bytes
      put_text("Content-Length: 2\r\n\r\n");
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      flush_bytes();

      // register extremes and the boundary at the limit itself
      set_limit('0);
      frame("Content-Length: 0\r\n\r\n", 0);
      frame("Content-Length: 1\r\n\r\n", 0);
      set_limit(LENGTH_BITS'(5));
      frame("Content-Length: 5\r\n\r\n", 5);
      frame("Content-Length: 6\r\n\r\n", 0);
      set_limit('1);

      // random: mostly well-formed frames, some broken headers and raw noise
      random_target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < random_target) begin
         if (bytes_sent > random_target - CALM_BYTES) begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         else begin
            if ($urandom_range(0, 11) == 0) begin
               gap_pct   = pick_pace();
               stall_pct = pick_pace();
            end
            if ($urandom_range(0, 14) == 0) begin
               case ($urandom_range(0, 3))
                  0:       set_limit('0);
                  1:       set_limit(LENGTH_BITS'($urandom_range(1, 64)));
                  2:       set_limit(LENGTH_BITS'($urandom));
                  default: set_limit('1);
               endcase
            end
            else if ($urandom_range(0, 24) == 0) begin
               drain_results();
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) good_message();
         else if (pick < 88) broken_message();
         else noise_message();
      end

      req_valid   <= 1'b0;
      wait_cycles = 0;
      do begin
         @(posedge clock);
         wait_cycles++;
      end while (responses_pending != 0 && wait_cycles < 20000);
      repeat (20) @(posedge clock);

      $display("sent %0d stream bytes over %0d length-limit settings",
               bytes_sent, limit_writes);
      $display("checked %0d body bytes, %0d empty messages and %0d header errors",
               body_count, empty_count, error_count);
      if (responses_pending != 0)
         $display("%0d expected responses never arrived", responses_pending);
      if (mismatch_total == 0 && responses_pending == 0) begin
         $display("RESULT: OK");
      end
      else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("run timed out");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/cld_pkg.sv
hdl/cld_front.sv
hdl/cld_queue.sv
hdl/cld_back.sv
hdl/content_length_message_deframer.sv
tb/deframe_checker.sv
tb/testbench.sv
